>>> rtl/bdg_pkg.sv
// Shared types, constants and codes for the button debounce / gesture detector.
package bdg_pkg;

  localparam int unsigned CFG_W          = 16;
  localparam int unsigned TIME_WIDTH_DEF = 16;
  localparam int unsigned Q_DEPTH        = 4;
  localparam int unsigned IDX_W          = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(40);
  localparam logic [CFG_W-1:0] LONG_RST     = CFG_W'(800);
  localparam logic [CFG_W-1:0] WINDOW_RST   = CFG_W'(400);

  typedef enum logic [IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_WINDOW   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    GEST_NONE   = 3'd0,
    GEST_SINGLE = 3'd1,
    GEST_DOUBLE = 3'd2,
    GEST_TRIPLE = 3'd3,
    GEST_LONG   = 3'd4
  } gesture_t;

  // Debounced edge seen on one tick
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } event_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] long_press_ticks;
    logic [CFG_W-1:0] click_window_ticks;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> rtl/bdg_front.sv
// Front end: debounces the raw level and classifies each tick into an edge event.
module bdg_front #(
  parameter int unsigned TIME_WIDTH = bdg_pkg::TIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic                   raw,
  input  logic [bdg_pkg::CFG_W-1:0] debounce_ticks,
  output bdg_pkg::event_t        ev
);

  localparam int unsigned CMP_W = (TIME_WIDTH > bdg_pkg::CFG_W) ? TIME_WIDTH : bdg_pkg::CFG_W;
  localparam logic [TIME_WIDTH-1:0] TMAX = '1;

  logic                  last_raw_r, last_raw_nxt;
  logic                  stable_r, stable_nxt;
  logic [TIME_WIDTH-1:0] age_r, age_nxt;
  logic                  stable_edge;

  always_comb begin
    if (raw != last_raw_r) begin
      age_nxt = '0;
    end else if (age_r == TMAX) begin
      age_nxt = age_r;
    end else begin
      age_nxt = age_r + 1'b1;
    end
    last_raw_nxt = raw;
    stable_edge  = (CMP_W'(age_nxt) >= CMP_W'(debounce_ticks)) && (raw != stable_r);
    stable_nxt   = stable_edge ? raw : stable_r;
    if (!stable_edge) begin
      ev = bdg_pkg::EV_NONE;
    end else if (!raw) begin
      ev = bdg_pkg::EV_PRESS;
    end else begin
      ev = bdg_pkg::EV_RELEASE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= 1'b1;
      stable_r   <= 1'b1;
      age_r      <= '0;
    end else if (accept) begin
      last_raw_r <= last_raw_nxt;
      stable_r   <= stable_nxt;
      age_r      <= age_nxt;
    end
  end

  a_press_low: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ev == bdg_pkg::EV_PRESS |-> !raw)
    else $error("press event on released raw level");

  a_edge_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    accept && stable_edge |=> stable_r == $past(raw))
    else $error("stable level did not follow edge");

  a_age_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && raw != last_raw_r |=> age_r == '0)
    else $error("debounce age not cleared on raw change");

endmodule

>>> rtl/bdg_queue.sv
// Short event queue between the debounce front end and the gesture back end.
module bdg_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bdg_pkg::event_t    push_ev,
  input  logic               pop,
  output bdg_pkg::event_t    pop_ev,
  output bdg_pkg::q_status_t status
);

  localparam int unsigned PTR_W = $clog2(bdg_pkg::Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(bdg_pkg::Q_DEPTH + 1);

  bdg_pkg::event_t  mem_r [bdg_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
    status.full  = (count_r == CNT_W'(bdg_pkg::Q_DEPTH));
    status.empty = (count_r == '0);
    pop_ev       = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ev;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    status.full |-> !push || pop)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    status.empty |-> !pop)
    else $error("pop from empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count lost a push");

endmodule

>>> rtl/bdg_back.sv
// Back end: press timer, click window and gesture classification, plus output register.
module bdg_back #(
  parameter int unsigned TIME_WIDTH = bdg_pkg::TIME_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  bdg_pkg::event_t q_ev,
  output logic            q_pop,
  input  bdg_pkg::cfg_t   cfg,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [2:0]      out_gesture
);

  localparam int unsigned CMP_W = (TIME_WIDTH > bdg_pkg::CFG_W) ? TIME_WIDTH : bdg_pkg::CFG_W;
  localparam logic [TIME_WIDTH-1:0] TMAX = '1;

  logic [TIME_WIDTH-1:0] press_age_r, press_age_nxt;
  logic                  press_valid_r, press_valid_nxt;
  logic                  long_rep_r, long_rep_nxt;
  logic [1:0]            clicks_r, clicks_nxt;
  logic [TIME_WIDTH-1:0] win_left_r, win_left_nxt;
  logic                  win_valid_r, win_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  bdg_pkg::gesture_t     gest_r, gest_nxt;
  logic [TIME_WIDTH-1:0] win_load;

  assign q_pop       = !q_empty && (!out_valid_r || !out_stall);
  assign out_valid   = out_valid_r;
  assign out_gesture = gest_r;

  assign win_load = (CMP_W'(cfg.click_window_ticks) > CMP_W'(TMAX)) ?
                    TMAX : TIME_WIDTH'(cfg.click_window_ticks);

  always_comb begin
    press_age_nxt   = press_age_r;
    press_valid_nxt = press_valid_r;
    long_rep_nxt    = long_rep_r;
    clicks_nxt      = clicks_r;
    win_left_nxt    = win_left_r;
    win_valid_nxt   = win_valid_r;
    gest_nxt        = bdg_pkg::GEST_NONE;

    if (win_valid_r && win_left_r != '0) begin
      win_left_nxt = win_left_r - 1'b1;
    end
    if (press_valid_r && press_age_r != TMAX) begin
      press_age_nxt = press_age_r + 1'b1;
    end

    if (q_ev == bdg_pkg::EV_PRESS) begin
      // press edge: start timing, no gesture tests this tick
      press_age_nxt   = '0;
      press_valid_nxt = 1'b1;
      long_rep_nxt    = 1'b0;
    end else begin
      if (q_ev == bdg_pkg::EV_RELEASE) begin
        if (!long_rep_r) begin
          if (clicks_r != 2'd3) begin
            clicks_nxt = clicks_r + 1'b1;
          end
          win_left_nxt  = win_load;
          win_valid_nxt = 1'b1;
        end
        press_valid_nxt = 1'b0;
      end

      // press_valid doubles as "stable level is pressed"
      if (press_valid_nxt && !long_rep_nxt &&
          CMP_W'(press_age_nxt) >= CMP_W'(cfg.long_press_ticks)) begin
        long_rep_nxt  = 1'b1;
        clicks_nxt    = '0;
        win_valid_nxt = 1'b0;
        win_left_nxt  = '0;
        gest_nxt      = bdg_pkg::GEST_LONG;
      end else if (clicks_nxt != '0 && win_valid_nxt && win_left_nxt == '0) begin
        gest_nxt      = bdg_pkg::gesture_t'({1'b0, clicks_nxt});
        clicks_nxt    = '0;
        win_valid_nxt = 1'b0;
      end
    end

    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_age_r   <= '0;
      press_valid_r <= 1'b0;
      long_rep_r    <= 1'b0;
      clicks_r      <= '0;
      win_left_r    <= '0;
      win_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        press_age_r   <= press_age_nxt;
        press_valid_r <= press_valid_nxt;
        long_rep_r    <= long_rep_nxt;
        clicks_r      <= clicks_nxt;
        win_left_r    <= win_left_nxt;
        win_valid_r   <= win_valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      gest_r <= gest_nxt;
    end
  end

  a_clicks_window: assert property (@(posedge clk) disable iff (!rst_n)
    (clicks_r != '0) == win_valid_r)
    else $error("pending clicks without an open window");

  a_long_marks: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && gest_nxt == bdg_pkg::GEST_LONG |=> long_rep_r && clicks_r == '0)
    else $error("long press left stale state");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !q_pop |=> $stable(clicks_r) && $stable(press_age_r) && $stable(win_left_r))
    else $error("gesture state moved without a request");

endmodule

>>> rtl/button_debounce_gesture_detector.sv
// Top level: config registers, debounce front end, event queue and gesture back end.
// A request's event is written into the event queue; the back end pops it and registers its result for the output.
// Throughput: one request per cycle while in_stall is low; the press timer and click window advance once per request.
// A four-entry event queue lets the front end keep accepting, until it is full, while the output is stalled.
// Reset (synchronous, active low): button released, timers and clicks cleared, config at
// defaults (debounce 40, long press 800, click window 400 ticks).
module button_debounce_gesture_detector #(
  parameter int unsigned TIME_WIDTH = bdg_pkg::TIME_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_raw_level,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                out_gesture,
  input  logic                      cfg_we,
  input  logic [bdg_pkg::IDX_W-1:0] cfg_index,
  input  logic [bdg_pkg::CFG_W-1:0] cfg_wdata
);

  bdg_pkg::cfg_t      cfg_r;
  bdg_pkg::q_status_t q_status;
  bdg_pkg::event_t    front_ev;
  bdg_pkg::event_t    q_ev;
  logic               in_accept;
  logic               q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks     <= bdg_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ticks   <= bdg_pkg::LONG_RST;
      cfg_r.click_window_ticks <= bdg_pkg::WINDOW_RST;
    end else if (cfg_we) begin
      case (bdg_pkg::reg_idx_t'(cfg_index))
        bdg_pkg::REG_DEBOUNCE: cfg_r.debounce_ticks     <= cfg_wdata;
        bdg_pkg::REG_LONG:     cfg_r.long_press_ticks   <= cfg_wdata;
        bdg_pkg::REG_WINDOW:   cfg_r.click_window_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall  = q_status.full;
  assign in_accept = in_valid && !q_status.full;

  bdg_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .raw           (in_raw_level),
    .debounce_ticks(cfg_r.debounce_ticks),
    .ev            (front_ev)
  );

  bdg_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_accept),
    .push_ev(front_ev),
    .pop    (q_pop),
    .pop_ev (q_ev),
    .status (q_status)
  );

  bdg_back #(.TIME_WIDTH(TIME_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_status.empty),
    .q_ev       (q_ev),
    .q_pop      (q_pop),
    .cfg        (cfg_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_gesture(out_gesture)
  );

endmodule
